// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg: shared definitions for the LRU page replacement block
// Sizes, the broadcast and chain structs, and the status record of one frame cell.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int FRAMES    = 4;
	localparam int PAGE_BITS = 20;
	localparam int RANK_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int SLOT_W    = 2;
	localparam int COUNT_W   = 32;

	localparam logic [RANK_W-1:0]  RANK_OLDEST = RANK_W'(FRAMES - 1);
	localparam logic [COUNT_W-1:0] FAULT_MAX   = '1;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [RANK_W-1:0]    rank_t;

	typedef enum logic [1:0] {
		MODE_HIT   = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_EVICT = 2'd2
	} mode_t;

	typedef struct packed {
		page_t page;
		logic  clear;
		mode_t mode;
		rank_t limit;
	} bcast_t;

	typedef struct packed {
		logic hit_seen;
		logic empty_seen;
		logic victim_seen;
	} chain_t;

	typedef struct packed {
		logic  sel;
		rank_t rank;
		page_t page;
	} stat_t;

endpackage

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative page frames with LRU replacement
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_ready, page_number,             | to block
//           | first_reference                              |
//   out     | out_valid, out_ready, hit, frame_slot,       | from block
//           | evicted_valid, evicted_page, fault_total     |
//
// One reference per cycle: the frame cells compare, pick a frame and age their
// ranks in the cycle of the transfer, and the result is captured at the accepting
// edge and offered from the next cycle on.
// The single output register frees in the same cycle that its result is taken,
// so the input stalls only while out_ready is low with a result held.
// Reset empties every frame and zeroes the fault count.
// ----------------------------------------------------------------------------
module lru_page_replacement (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lrupr_pkg::PAGE_BITS-1:0]     page_number,
	input  logic                                first_reference,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [lrupr_pkg::SLOT_W-1:0]        frame_slot,
	output logic                                evicted_valid,
	output logic [lrupr_pkg::PAGE_BITS-1:0]     evicted_page,
	output logic [lrupr_pkg::COUNT_W-1:0]       fault_total
);

	lrupr_pkg::bcast_t bcast;
	lrupr_pkg::chain_t chain [lrupr_pkg::FRAMES+1];
	lrupr_pkg::stat_t  stat  [lrupr_pkg::FRAMES];

	logic                                upd;
	logic                                any_hit;
	logic                                any_empty;
	lrupr_pkg::rank_t                    sel_rank;
	lrupr_pkg::page_t                    sel_page;
	logic [lrupr_pkg::SLOT_W-1:0]        sel_slot;
	logic [lrupr_pkg::COUNT_W-1:0]       count_base;
	logic [lrupr_pkg::COUNT_W-1:0]       count_next;
	logic [lrupr_pkg::COUNT_W-1:0]       fault_q;

	assign in_ready = ~out_valid | out_ready;
	assign upd      = in_valid & in_ready;

	assign chain[0]  = '0;
	assign any_hit   = chain[lrupr_pkg::FRAMES].hit_seen;
	assign any_empty = chain[lrupr_pkg::FRAMES].empty_seen;

	always_comb begin
		bcast.page  = page_number;
		bcast.clear = first_reference;
		if (any_hit) begin
			bcast.mode = lrupr_pkg::MODE_HIT;
		end else if (any_empty) begin
			bcast.mode = lrupr_pkg::MODE_FILL;
		end else begin
			bcast.mode = lrupr_pkg::MODE_EVICT;
		end
		bcast.limit = sel_rank;
	end

	for (genvar g = 0; g < lrupr_pkg::FRAMES; g++) begin : g_cell
		lrupr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd       (upd),
			.bcast     (bcast),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.stat      (stat[g])
		);
	end

	always_comb begin
		sel_rank = '0;
		sel_page = '0;
		sel_slot = '0;
		for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
			if (stat[i].sel) begin
				sel_rank = sel_rank | stat[i].rank;
				sel_page = sel_page | stat[i].page;
				sel_slot = sel_slot | lrupr_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		count_base = first_reference ? '0 : fault_q;
		count_next = count_base;
		if (!any_hit && (count_base != lrupr_pkg::FAULT_MAX)) begin
			count_next = count_base + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			fault_q   <= '0;
		end else begin
			if (upd) begin
				out_valid <= 1'b1;
				fault_q   <= count_next;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			hit           <= any_hit;
			frame_slot    <= sel_slot;
			evicted_valid <= ~any_hit & ~any_empty;
			evicted_page  <= (~any_hit & ~any_empty) ? sel_page : '0;
			fault_total   <= count_next;
		end
	end

endmodule

// ===== src/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell: one page frame of the LRU set
// Holds a page, its valid bit and its age rank, claims the item in priority order
// along the chain, and ages, loads or clears itself when a transfer is taken.
// ----------------------------------------------------------------------------
module lrupr_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  lrupr_pkg::bcast_t bcast,
	input  lrupr_pkg::chain_t chain_in,
	output lrupr_pkg::chain_t chain_out,
	output lrupr_pkg::stat_t  stat
);

	lrupr_pkg::page_t page_q;
	logic             valid_q;
	lrupr_pkg::rank_t rank_q;

	logic valid_eff;
	logic match;
	logic victim;
	logic sel;

	always_comb begin
		valid_eff = valid_q & ~bcast.clear;
		match     = valid_eff && (page_q == bcast.page);
		victim    = valid_eff && (rank_q == lrupr_pkg::RANK_OLDEST);

		chain_out.hit_seen    = chain_in.hit_seen | match;
		chain_out.empty_seen  = chain_in.empty_seen | ~valid_eff;
		chain_out.victim_seen = chain_in.victim_seen | victim;

		case (bcast.mode)
			lrupr_pkg::MODE_HIT:   sel = match & ~chain_in.hit_seen;
			lrupr_pkg::MODE_FILL:  sel = ~valid_eff & ~chain_in.empty_seen;
			lrupr_pkg::MODE_EVICT: sel = victim & ~chain_in.victim_seen;
			default:               sel = 1'b0;
		endcase

		stat.sel  = sel;
		stat.rank = rank_q;
		stat.page = page_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd) begin
			if (sel) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (bcast.clear) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (valid_q && ((bcast.mode == lrupr_pkg::MODE_FILL)
					|| (rank_q < bcast.limit))) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd && sel) begin
			page_q <= bcast.page;
		end
	end

endmodule

// ===== src/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// lrupr_checker: port-level checks for the LRU page replacement block
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module lrupr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                first_reference,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                hit,
	input logic [lrupr_pkg::SLOT_W-1:0]        frame_slot,
	input logic                                evicted_valid,
	input logic [lrupr_pkg::PAGE_BITS-1:0]     evicted_page,
	input logic [lrupr_pkg::COUNT_W-1:0]       fault_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(frame_slot)
			&& $stable(evicted_page) && $stable(fault_total))
		else $error("Result changed while stalled.");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("A hit reported an eviction.");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("Evicted page is nonzero without an eviction.");

	a_first_ref: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && first_reference |=> out_valid && !hit
			&& !evicted_valid && frame_slot == '0 && fault_total == 32'd1)
		else $error("First reference did not fault into an empty set.");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.first_reference (first_reference),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.hit             (hit),
	.frame_slot      (frame_slot),
	.evicted_valid   (evicted_valid),
	.evicted_page    (evicted_page),
	.fault_total     (fault_total)
);

// ===== dv/lru_frame_check_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_frame_check_pkg: result tracking for the LRU page replacement testbench
// Keeps an independent copy of the frame table, works out the result of every
// accepted reference and compares each returned result with the oldest one due.
// ----------------------------------------------------------------------------
package lru_frame_check_pkg;

	import lrupr_pkg::*;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               ev_valid;
		page_t              ev_page;
		logic [COUNT_W-1:0] faults;
	} ref_result_t;

	class lru_frame_tracker;

		page_t              frame_pages [FRAMES];
		logic               frame_full  [FRAMES];
		rank_t              frame_age   [FRAMES];
		logic [COUNT_W-1:0] fault_tally;
		ref_result_t        due_results [$];
		int                 mismatches;

		function new();
			empty_frames();
			mismatches = 0;
		endfunction

		function void empty_frames();
			for (int i = 0; i < FRAMES; i++) begin
				frame_pages[i] = '0;
				frame_full[i]  = 1'b0;
				frame_age[i]   = '0;
			end
			fault_tally = '0;
		endfunction

		// Frame f becomes the youngest; every occupied frame younger than limit ages by one.
		function void promote(int f, int limit);
			for (int i = 0; i < FRAMES; i++) begin
				if (i != f && frame_full[i] && int'(frame_age[i]) < limit)
					frame_age[i] = frame_age[i] + 1'b1;
			end
			frame_age[f] = '0;
		endfunction

		function void note_reference(page_t pg, logic clear);
			ref_result_t r;
			int          slot;
			r    = '0;
			slot = -1;
			if (clear)
				empty_frames();
			for (int i = 0; i < FRAMES; i++) begin
				if (slot < 0 && frame_full[i] && frame_pages[i] == pg)
					slot = i;
			end
			if (slot >= 0) begin
				r.hit = 1'b1;
				promote(slot, int'(frame_age[slot]));
			end else begin
				for (int i = 0; i < FRAMES; i++) begin
					if (slot < 0 && !frame_full[i])
						slot = i;
				end
				if (slot >= 0) begin
					promote(slot, FRAMES + 1);
				end else begin
					slot = 0;
					for (int i = 1; i < FRAMES; i++) begin
						if (frame_age[i] > frame_age[slot])
							slot = i;
					end
					r.ev_valid = 1'b1;
					r.ev_page  = frame_pages[slot];
					promote(slot, int'(frame_age[slot]));
				end
				frame_pages[slot] = pg;
				frame_full[slot]  = 1'b1;
				if (fault_tally != FAULT_MAX)
					fault_tally = fault_tally + 1'b1;
			end
			r.slot   = SLOT_W'(slot);
			r.faults = fault_tally;
			due_results.push_back(r);
		endfunction

		function void check_result(logic hit, logic [SLOT_W-1:0] slot, logic ev_valid,
				page_t ev_page, logic [COUNT_W-1:0] faults);
			ref_result_t exp_r;
			if (due_results.size() == 0) begin
				$error("result transfer with no reference outstanding");
				mismatches++;
				return;
			end
			exp_r = due_results.pop_front();
			if (hit !== exp_r.hit) begin
				$error("hit: expected %0d, got %0d", exp_r.hit, hit);
				mismatches++;
			end
			if (slot !== exp_r.slot) begin
				$error("frame_slot: expected %0d, got %0d", exp_r.slot, slot);
				mismatches++;
			end
			if (ev_valid !== exp_r.ev_valid) begin
				$error("evicted_valid: expected %0d, got %0d", exp_r.ev_valid, ev_valid);
				mismatches++;
			end
			if (ev_page !== exp_r.ev_page) begin
				$error("evicted_page: expected 0x%05h, got 0x%05h", exp_r.ev_page, ev_page);
				mismatches++;
			end
			if (faults !== exp_r.faults) begin
				$error("fault_total: expected %0d, got %0d", exp_r.faults, faults);
				mismatches++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction

	endclass

endpackage

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the LRU page replacement block
// Drives a directed run over fills, hits, evictions and clears, then random
// references drawn mostly from a small working set, with random idling on both
// sides, a long receiver stall and a full drain pause. Every result is checked.
// ----------------------------------------------------------------------------
module tb_top;

	import lrupr_pkg::*;
	import lru_frame_check_pkg::*;

	localparam int RANDOM_REFS = 1030;
	localparam int CALM_REFS   = 150;
	localparam int CYCLE_LIMIT = 200000;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_ready;
	page_t              page_number     = '0;
	logic               first_reference = 1'b0;
	logic               out_valid;
	logic               out_ready       = 1'b0;
	logic               hit;
	logic [SLOT_W-1:0]  frame_slot;
	logic               evicted_valid;
	page_t              evicted_page;
	logic [COUNT_W-1:0] fault_total;

	logic calm = 1'b0;
	int   cycle_count = 0;

	lru_frame_tracker board = new();

	lru_page_replacement DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.page_number     (page_number),
		.first_reference (first_reference),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.frame_slot      (frame_slot),
		.evicted_valid   (evicted_valid),
		.evicted_page    (evicted_page),
		.fault_total     (fault_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_ref(input page_t pg, input logic clear);
		page_number     <= pg;
		first_reference <= clear;
		in_valid        <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_reference(pg, clear);
	endtask

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	initial begin : receiver
		int  stall_left;
		int  results_seen;
		logic held;
		stall_left   = 0;
		results_seen = 0;
		held         = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_result(hit, frame_slot, evicted_valid, evicted_page, fault_total);
				results_seen++;
			end
			if (results_seen == 300 && !held) begin
				held       = 1'b1;
				stall_left = 60;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		page_t hot_pages [6];
		page_t pg;
		logic  clear;
		int    pick;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Page zero must miss while every frame is empty.
		send_ref(20'h00000, 1'b0);
		send_ref(20'hFFFFF, 1'b0);
		send_ref(20'h00000, 1'b0);
		send_ref(20'h00001, 1'b0);
		send_ref(20'h80000, 1'b0);
		send_ref(20'hAAAAA, 1'b0);
		send_ref(20'h55555, 1'b0);
		send_ref(20'h00000, 1'b0);
		send_ref(20'h80000, 1'b0);
		send_ref(20'hFFFFF, 1'b0);
		send_ref(20'hAAAAA, 1'b0);
		send_ref(20'h00000, 1'b1);
		send_ref(20'h00000, 1'b1);
		send_ref(20'h00000, 1'b0);
		send_ref(20'h12345, 1'b0);
		send_ref(20'h6789A, 1'b0);
		send_ref(20'hFFFFF, 1'b0);
		send_ref(20'h54321, 1'b0);
		send_ref(20'h12345, 1'b0);
		send_ref(20'hFFFFF, 1'b1);
		send_ref(20'hFFFFF, 1'b0);

		for (int i = 0; i < 6; i++)
			hot_pages[i] = page_t'($urandom);

		for (int n = 0; n < RANDOM_REFS; n++) begin
			if (n == RANDOM_REFS - CALM_REFS)
				calm = 1'b1;
			if (n == 500) begin
				idle_input(1);
				while (board.pending() != 0)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				idle_input($urandom_range(1, 11));
			end
			if ($urandom_range(0, 19) == 0)
				hot_pages[$urandom_range(0, 5)] = page_t'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				pg = hot_pages[$urandom_range(0, 5)];
			end else if (pick < 95) begin
				pg = page_t'($urandom);
			end else begin
				case ($urandom_range(0, 2))
					0: pg = '0;
					1: pg = '1;
					default: pg = page_t'(1) << $urandom_range(0, PAGE_BITS - 1);
				endcase
			end
			clear = ($urandom_range(0, 39) == 0);
			send_ref(pg, clear);
		end
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (5)
			@(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
